// File: design/wmm_pkg.sv
// Package: shared types, widths and helpers for the window min/max/mean block.
`timescale 1ns / 1ps
`default_nettype none

package wmm_pkg;

  localparam int SAMPLE_W = 12;
  localparam int COUNT_W  = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]         count_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // write the accepted sample into the ring
    logic rd_en;     // read one ring entry
    logic rd_first;  // this read is the first of the walk
    logic div_init;  // load the divider from the accumulated sum
    logic div_step;  // one restoring-divide step
    logic out_load;  // move the finished result into the output register
  } wmm_cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic out_busy;  // output register holds a beat not yet taken
  } wmm_status_t;

  // Ring index width (at least one bit)
  function automatic int wmm_idx_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width that holds a count from 0 up to depth
  function automatic int wmm_cnt_w(input int depth);
    return $clog2(depth + 1);
  endfunction

  // Signed width of the running sum
  function automatic int wmm_sum_w(input int depth);
    return SAMPLE_W + wmm_cnt_w(depth);
  endfunction

endpackage

`default_nettype wire

// File: design/wmm_if.sv
// Interfaces: sample input channel and statistics output channel.
`timescale 1ns / 1ps
`default_nettype none

interface wmm_sample_if import wmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_tenths;

  modport source (output valid, output sample_tenths, input ready);
  modport sink   (input valid, input sample_tenths, output ready);
endinterface

interface wmm_stats_if import wmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t min_tenths;
  sample_t max_tenths;
  sample_t mean_tenths;
  count_t  valid_count;

  modport source (output valid, output min_tenths, output max_tenths,
                  output mean_tenths, output valid_count, input ready);
  modport sink   (input valid, input min_tenths, input max_tenths,
                  input mean_tenths, input valid_count, output ready);
endinterface

`default_nettype wire

// File: design/wmm_ctrl.sv
// Controller: ring write pointer, fill state, window walk and divide sequencing.
`timescale 1ns / 1ps
`default_nettype none

module wmm_ctrl import wmm_pkg::*; #(
  parameter int  WINDOW_DEPTH = 4,
  localparam int IDX_W = wmm_idx_w(WINDOW_DEPTH),
  localparam int CNT_W = wmm_cnt_w(WINDOW_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  output wmm_cmd_t               cmd,
  output logic [IDX_W-1:0]       wr_addr,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [CNT_W-1:0]       count,
  input  wire wmm_status_t       status
);

  localparam int NUM_W  = wmm_sum_w(WINDOW_DEPTH) + 1;
  localparam int DCNT_W = $clog2(NUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  widx;
  logic              full;
  logic [IDX_W-1:0]  rd_i;
  logic [DCNT_W-1:0] div_cnt;

  logic [IDX_W-1:0]  widx_next;
  logic              wrap;
  logic              full_next;
  logic              accept;
  logic              scan_last;

  assign accept    = sample_valid && sample_ready;
  assign wrap      = (widx == IDX_W'(WINDOW_DEPTH - 1));
  assign widx_next = wrap ? '0 : widx + 1'b1;
  assign full_next = full || wrap;
  assign scan_last = (CNT_W'(rd_i) == count - 1'b1);

  assign sample_ready = (state == ST_IDLE);
  assign wr_addr      = widx;
  assign rd_addr      = rd_i;

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = accept;
    cmd.rd_en    = (state == ST_SCAN);
    cmd.rd_first = (state == ST_SCAN) && (rd_i == '0);
    cmd.div_init = (state == ST_DINIT);
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = (state == ST_DONE) && !status.out_busy;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      widx    <= '0;
      full    <= 1'b0;
      count   <= '0;
      rd_i    <= '0;
      div_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            widx  <= widx_next;
            full  <= full_next;
            count <= full_next ? CNT_W'(WINDOW_DEPTH) : CNT_W'(widx_next);
            rd_i  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_DRAIN;
          end else begin
            rd_i <= rd_i + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_DINIT;
        end
        ST_DINIT: begin
          div_cnt <= DCNT_W'(NUM_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_DONE;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (!status.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Count is never zero while an item is in flight
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (count != '0))
    else $error("window count is zero during processing");

  // Count never exceeds the window depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(WINDOW_DEPTH)))
    else $error("window count above depth");

  // Walk stays inside the valid entries
  a_read_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (CNT_W'(rd_i) < count))
    else $error("ring read beyond valid entries");

  // Once full, the window stays full
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("full flag dropped");

endmodule

`default_nettype wire

// File: design/wmm_dp.sv
// Datapath: sample ring memory, min/max/sum accumulators, divider, output register.
`timescale 1ns / 1ps
`default_nettype none

module wmm_dp import wmm_pkg::*; #(
  parameter int  WINDOW_DEPTH = 4,
  localparam int IDX_W = wmm_idx_w(WINDOW_DEPTH),
  localparam int CNT_W = wmm_cnt_w(WINDOW_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wmm_cmd_t      cmd,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [IDX_W-1:0] rd_addr,
  input  wire logic [CNT_W-1:0] count,
  input  wire sample_t       sample_in,
  output wmm_status_t        status,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sample_t            min_out,
  output sample_t            max_out,
  output sample_t            mean_out,
  output count_t             count_out
);

  localparam int SUM_W = wmm_sum_w(WINDOW_DEPTH);
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = CNT_W + 1;

  // Ring storage
  sample_t mem [WINDOW_DEPTH];
  sample_t rdata;
  logic    rd_v;
  logic    rd_first_q;

  // Accumulators
  sample_t                  lo;
  sample_t                  hi;
  logic signed [SUM_W-1:0]  sum;

  // Divider
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic             neg;

  logic signed [SUM_W-1:0] rdata_ext;
  logic [SUM_W-1:0]        mag;
  logic [DEN_W:0]          trial;
  logic [DEN_W:0]          diff;
  logic                    take;
  sample_t                 quot;

  assign rdata_ext = {{(SUM_W - SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
  assign mag       = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial     = {rem, num[NUM_W-1]};
  assign diff      = trial - {1'b0, den};
  assign take      = (trial >= {1'b0, den});
  assign quot      = num[SAMPLE_W-1:0];

  assign status.out_busy = out_valid && !out_ready;

  // Ring write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= sample_in;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Read-data valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v       <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_v       <= cmd.rd_en;
      rd_first_q <= cmd.rd_first;
    end
  end

  // Min, max and sum over the walked entries
  always_ff @(posedge clk) begin
    if (rd_v) begin
      if (rd_first_q) begin
        lo  <= rdata;
        hi  <= rdata;
        sum <= rdata_ext;
      end else begin
        if (rdata < lo) lo <= rdata;
        if (rdata > hi) hi <= rdata;
        sum <= sum + rdata_ext;
      end
    end
  end

  // Restoring divide of (2|sum| + n) by 2n, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg <= sum[SUM_W-1];
      num <= {mag, 1'b0} + NUM_W'(count);
      den <= {count, 1'b0};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (take) begin
        rem <= diff[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      min_out   <= lo;
      max_out   <= hi;
      mean_out  <= neg ? -quot : quot;
      count_out <= COUNT_W'(count);
    end
  end

  // A new result never overwrites a beat still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output overwritten while stalled");

  // Accumulated range is ordered when the divide starts
  a_lo_le_hi: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> (lo <= hi))
    else $error("min above max");

  // Walk and divide never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en || rd_v) |-> !(cmd.div_init || cmd.div_step))
    else $error("walk overlaps divide");

endmodule

`default_nettype wire

// File: design/window_min_max_mean_top.sv
// Top level: sliding-window min/max/mean over temperature samples.
//
// Usage:
//   samples : input channel, one beat per temperature sample (signed tenths).
//   stats   : output channel, one beat per sample with min, max, rounded mean
//             (ties away from zero) and the number of valid window entries.
//   Each accepted sample is written into a ring of WINDOW_DEPTH entries; the
//   statistics cover the entries written so far, or the whole ring once full.
// Timing:
//   One sample is processed at a time. From acceptance, the controller walks
//   the n valid entries through the ring memory's single read port, whose
//   read data is registered, loads the divider, then runs a restoring
//   divide of one bit a cycle over 13 + log2(WINDOW_DEPTH+1) rounded up steps.
// Reset: rst clears the write index and the full flag; the window restarts
//   empty. Ring contents are not cleared; unwritten entries are never read.
// Stall: a finished beat waits in the output register; samples accepts one
//   more sample while it waits, and that result, and the input, hold until
//   the waiting beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module window_min_max_mean_top import wmm_pkg::*; #(
  parameter int WINDOW_DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  wmm_sample_if.sink     samples,
  wmm_stats_if.source    stats
);

  localparam int IDX_W = wmm_idx_w(WINDOW_DEPTH);
  localparam int CNT_W = wmm_cnt_w(WINDOW_DEPTH);

  wmm_cmd_t          cmd;
  wmm_status_t       status;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  count;

  wmm_ctrl #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (samples.valid),
    .sample_ready (samples.ready),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .count        (count),
    .status       (status)
  );

  wmm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .count     (count),
    .sample_in (samples.sample_tenths),
    .status    (status),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .min_out   (stats.min_tenths),
    .max_out   (stats.max_tenths),
    .mean_out  (stats.mean_tenths),
    .count_out (stats.valid_count)
  );

endmodule

`default_nettype wire

// File: test/window_min_max_mean_top_tb.sv
// Testbench: random and directed samples against a predictor of the window statistics.
`timescale 1ns / 1ps

module window_min_max_mean_top_tb;
  import wmm_pkg::*;

  localparam int DEPTH = 4;
  localparam int MAX_WAIT = 11;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t lo;
    sample_t hi;
    sample_t mean;
    count_t  count;
  } stats_beat_t;

  logic clk;
  logic rst;

  wmm_sample_if samples_ch ();
  wmm_stats_if  stats_ch ();

  window_min_max_mean_top #(
    .WINDOW_DEPTH(DEPTH)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_ch),
    .stats  (stats_ch)
  );

  // Predictor state: shadow ring, write index and full flag
  sample_t     shadow_ring[DEPTH];
  int unsigned shadow_wr_idx;
  bit          shadow_full;

  sample_t     sample_queue[$];
  stats_beat_t pending_stats[$];
  int          samples_accepted;
  int          mismatch_count;

  // Beat flags, captured at the rising edge for the falling-edge driver
  logic        sample_fire;
  logic        stats_fire;

  // Driver bookkeeping
  int          send_gap;
  int          recv_stall;
  bit          send_burst;
  bit          recv_burst;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Write the sample, then min/max/rounded mean over the valid entries
  function automatic stats_beat_t window_stats(input sample_t s);
    stats_beat_t r;
    int unsigned n;
    int          sum;
    int unsigned mag;
    int unsigned q;
    int          mean;
    shadow_ring[shadow_wr_idx] = s;
    shadow_wr_idx = (shadow_wr_idx + 1) % DEPTH;
    if (shadow_wr_idx == 0) shadow_full = 1'b1;
    n = shadow_full ? DEPTH : shadow_wr_idx;
    sum = 0;
    r.lo = shadow_ring[0];
    r.hi = shadow_ring[0];
    for (int i = 0; i < n; i++) begin
      sum += int'(shadow_ring[i]);
      if (shadow_ring[i] < r.lo) r.lo = shadow_ring[i];
      if (shadow_ring[i] > r.hi) r.hi = shadow_ring[i];
    end
    // nearest tenth, exact halves away from zero
    mag = (sum < 0) ? -sum : sum;
    q = (2 * mag + n) / (2 * n);
    mean = (sum < 0) ? -int'(q) : int'(q);
    r.mean = sample_t'(mean);
    r.count = count_t'(n);
    return r;
  endfunction

  // Per-item wait; zero throughout a burst stretch
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  task automatic log_mismatch(input bit has_want, input stats_beat_t want,
                              input stats_beat_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      if (!has_want)
        $display("[%0t] stats beat with nothing pending: min %0d max %0d mean %0d count %0d",
                 $realtime, got.lo, got.hi, got.mean, got.count);
      else begin
        $write("[%0t] stats mismatch: exp min %0d max %0d mean %0d count %0d,",
               $realtime, want.lo, want.hi, want.mean, want.count);
        $display(" got min %0d max %0d mean %0d count %0d",
                 got.lo, got.hi, got.mean, got.count);
      end
    end
  endtask

  // Monitor: check stats beats, predict on sample beats
  always @(posedge clk) begin
    stats_beat_t got;
    stats_beat_t want;
    if (rst) begin
      sample_fire <= 1'b0;
      stats_fire  <= 1'b0;
    end else begin
      sample_fire <= samples_ch.valid && samples_ch.ready;
      stats_fire  <= stats_ch.valid && stats_ch.ready;
      if (stats_ch.valid && stats_ch.ready) begin
        got.lo    = stats_ch.min_tenths;
        got.hi    = stats_ch.max_tenths;
        got.mean  = stats_ch.mean_tenths;
        got.count = stats_ch.valid_count;
        if (pending_stats.size() == 0) begin
          log_mismatch(1'b0, got, got);
        end else begin
          want = pending_stats.pop_front();
          if (got.lo !== want.lo || got.hi !== want.hi ||
              got.mean !== want.mean || got.count !== want.count)
            log_mismatch(1'b1, want, got);
        end
      end
      if (samples_ch.valid && samples_ch.ready) begin
        pending_stats.push_back(window_stats(samples_ch.sample_tenths));
        samples_accepted++;
      end
    end
  end

  // Driver: sample source and stats ready, both with random waits
  always @(negedge clk) begin
    logic    nxt_valid;
    sample_t nxt_data;
    logic    nxt_ready;
    if (!rst) begin
      nxt_valid = samples_ch.valid;
      nxt_data  = samples_ch.sample_tenths;
      if (sample_fire) begin
        nxt_valid = 1'b0;
        send_gap  = draw_wait(send_burst);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sample_queue.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data  = sample_queue.pop_front();
        end
      end
      samples_ch.valid         <= nxt_valid;
      samples_ch.sample_tenths <= nxt_data;

      if (stats_fire) recv_stall = draw_wait(recv_burst);
      if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      stats_ch.ready <= nxt_ready;
    end
  end

  // Stimulus and end of run
  initial begin
    int      total;
    int      pick;
    sample_t last;
    sample_t corner[6];
    rst                      = 1'b1;
    samples_ch.valid         = 1'b0;
    samples_ch.sample_tenths = '0;
    stats_ch.ready           = 1'b0;
    samples_accepted         = 0;
    mismatch_count           = 0;
    send_gap                 = 0;
    recv_stall               = 0;
    send_burst               = 1'b0;
    recv_burst               = 1'b0;
    shadow_wr_idx            = 0;
    shadow_full              = 1'b0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    corner = '{-12'sd2048, 12'sd2047, -12'sd400, 12'sd1250, 12'sd0, -12'sd1};

    // Filling window: counts 1..4, halves at count 2 and 4 (both signs)
    sample_queue = '{12'sd1, 12'sd2, -12'sd6, 12'sd1};
    // Full-scale extremes, then the sensor range limits
    repeat (4) sample_queue.push_back(12'sd2047);
    repeat (4) sample_queue.push_back(-12'sd2048);
    repeat (2) begin
      sample_queue.push_back(-12'sd400);
      sample_queue.push_back(12'sd1250);
    end
    // Negative then positive exact halves over a full window
    sample_queue.push_back(12'sd0);
    sample_queue.push_back(-12'sd1);
    sample_queue.push_back(-12'sd1);
    sample_queue.push_back(12'sd0);
    sample_queue.push_back(12'sd1);
    sample_queue.push_back(12'sd1);
    sample_queue.push_back(12'sd0);
    sample_queue.push_back(12'sd0);

    // Random part: mostly sensor range, some full 12-bit, corners, clusters
    last = '0;
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      last = sample_t'(int'($urandom_range(0, 1650)) - 400);
      else if (pick < 75) last = sample_t'($urandom);
      else if (pick < 85) last = corner[$urandom_range(0, 5)];
      else                last = sample_t'(int'(last) + int'($urandom_range(0, 4)) - 2);
      sample_queue.push_back(last);
    end
    total = sample_queue.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (samples_accepted < total) @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
